FILE: rtl/core/stlc_pkg.sv
// Package with the word types, token kinds and character codes of the source tokenizer.
`default_nettype none

package stlc_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int MAX_LEXEME_DEF = 255;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [2:0] K_UNK = 3'd0;
    localparam logic [2:0] K_ID  = 3'd1;
    localparam logic [2:0] K_NUM = 3'd2;
    localparam logic [2:0] K_DIV = 3'd3;
    localparam logic [2:0] K_END = 3'd4;
    localparam logic [2:0] K_ERR = 3'd5;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  unknown_char;
        logic [7:0]  lexeme_length;
        logic [23:0] line_count;
        logic [23:0] empty_line_count;
        logic [23:0] comment_line_count;
        logic        last_of_run;
    } t_out_word;

endpackage

`default_nettype wire

FILE: rtl/core/source_tokenizer_line_counter.sv
// Top level of the source tokenizer with line, empty line and comment line counters.
// A byte's result words are written into the result queue when the byte is accepted.
// Throughput: one byte per cycle while the queue has room; two-token bytes fill two slots.
// The four-word result queue takes a byte only while it holds at most two words.
// Reset is synchronous and active low; it returns the lexer to idle and clears all counts.
// The same clean state is restored after every end-of-stream word.
`default_nettype none

module source_tokenizer_line_counter #(
    parameter int COUNT_BITS = stlc_pkg::COUNT_BITS_DEF,
    parameter int MAX_LEXEME = stlc_pkg::MAX_LEXEME_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  stlc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output stlc_pkg::t_out_word o_out_word
);

    localparam int CW = (COUNT_BITS < 24) ? COUNT_BITS : 24;
    localparam logic [7:0] LEX_CAP = 8'((MAX_LEXEME < 255) ? MAX_LEXEME : 255);
    localparam int QD = stlc_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int NW = $clog2(QD + 1);

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_SLASH  = 3'd3;
    localparam logic [2:0] M_LINE   = 3'd4;
    localparam logic [2:0] M_BLOCK  = 3'd5;
    localparam logic [2:0] M_BSTAR  = 3'd6;
    localparam logic [2:0] M_BEND   = 3'd7;

    logic [2:0]    r_mode, n_mode;
    logic          r_lsf, n_lsf;
    logic [CW-1:0] r_lines, n_lines;
    logic [CW-1:0] r_empty, n_empty;
    logic [CW-1:0] r_comm, n_comm;
    logic [7:0]    r_len, n_len;

    stlc_pkg::t_out_word r_queue [QD];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    stlc_pkg::t_out_word res0, res1;
    logic [1:0] res_n;
    logic       in_acc, out_acc;
    logic [7:0] c;
    logic       is_alpha, is_digit, is_space;
    logic       do_idle;
    logic [2:0] e_kind;
    logic [7:0] e_len;
    logic       e_valid;
    logic       u_valid;

    assign c        = i_in_word.byte_req;
    assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_space = (c == stlc_pkg::CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= NW'(QD - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_queue[r_rd_ptr];

    always_comb begin
        n_mode  = r_mode;
        n_lsf   = r_lsf;
        n_lines = r_lines;
        n_empty = r_empty;
        n_comm  = r_comm;
        n_len   = r_len;
        do_idle = 1'b0;
        e_valid = 1'b0;
        e_kind  = stlc_pkg::K_END;
        e_len   = 8'd0;
        u_valid = 1'b0;

        if (i_in_word.end_of_stream) begin
            e_valid = 1'b1;
            case (r_mode)
                M_IDENT: begin
                    e_kind = stlc_pkg::K_ID;
                    e_len  = r_len;
                end
                M_NUMBER: begin
                    e_kind = stlc_pkg::K_NUM;
                    e_len  = r_len;
                end
                M_SLASH: begin
                    e_kind = stlc_pkg::K_DIV;
                    e_len  = 8'd1;
                end
                M_BLOCK, M_BSTAR: begin
                    e_kind = stlc_pkg::K_ERR;
                end
                default: begin
                    e_valid = 1'b0;
                end
            endcase
            n_mode  = M_IDLE;
            n_lsf   = 1'b1;
            n_lines = '0;
            n_empty = '0;
            n_comm  = '0;
            n_len   = 8'd0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_alpha || is_digit || (c == stlc_pkg::CH_UNDER)) begin
                        if (r_len < LEX_CAP) begin
                            n_len = r_len + 8'd1;
                        end
                    end else begin
                        e_valid = 1'b1;
                        e_kind  = stlc_pkg::K_ID;
                        e_len   = r_len;
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit) begin
                        if (r_len < LEX_CAP) begin
                            n_len = r_len + 8'd1;
                        end
                    end else begin
                        e_valid = 1'b1;
                        e_kind  = stlc_pkg::K_NUM;
                        e_len   = r_len;
                        do_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == stlc_pkg::CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else if (c == stlc_pkg::CH_SLASH) begin
                        if (r_lsf && (r_comm != '1)) begin
                            n_comm = r_comm + 1'b1;
                        end
                        n_lsf  = 1'b0;
                        n_mode = M_LINE;
                    end else begin
                        n_lsf   = 1'b0;
                        e_valid = 1'b1;
                        e_kind  = stlc_pkg::K_DIV;
                        e_len   = 8'd1;
                        do_idle = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == stlc_pkg::CH_NL) begin
                        do_idle = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (c == stlc_pkg::CH_NL) begin
                        if (r_lines != '1) begin
                            n_lines = r_lines + 1'b1;
                        end
                        if (r_lsf && (r_comm != '1)) begin
                            n_comm = r_comm + 1'b1;
                        end
                    end else if (c == stlc_pkg::CH_STAR) begin
                        n_mode = M_BSTAR;
                    end
                end
                M_BSTAR: begin
                    if (c == stlc_pkg::CH_SLASH) begin
                        n_mode = M_BEND;
                    end else if (c != stlc_pkg::CH_STAR) begin
                        if (c == stlc_pkg::CH_NL) begin
                            if (r_lines != '1) begin
                                n_lines = r_lines + 1'b1;
                            end
                            if (r_lsf && (r_comm != '1)) begin
                                n_comm = r_comm + 1'b1;
                            end
                        end
                        n_mode = M_BLOCK;
                    end
                end
                M_BEND: begin
                    if ((c == stlc_pkg::CH_NL) && r_lsf && (r_comm != '1)) begin
                        n_comm = r_comm + 1'b1;
                    end
                    n_lsf   = 1'b0;
                    do_idle = 1'b1;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                n_mode = M_IDLE;
                if (is_space) begin
                    if (c == stlc_pkg::CH_NL) begin
                        if (r_lines != '1) begin
                            n_lines = r_lines + 1'b1;
                        end
                        if (n_lsf && (r_empty != '1)) begin
                            n_empty = r_empty + 1'b1;
                        end
                        n_lsf = 1'b1;
                    end
                end else if (c == stlc_pkg::CH_SLASH) begin
                    n_mode = M_SLASH;
                end else begin
                    n_lsf = 1'b0;
                    if (is_alpha) begin
                        n_mode = M_IDENT;
                        n_len  = 8'd1;
                    end else if (is_digit) begin
                        n_mode = M_NUMBER;
                        n_len  = 8'd1;
                    end else begin
                        u_valid = 1'b1;
                    end
                end
            end
        end
    end

    // Both words of one byte carry the counts from before the byte, since every token
    // of a byte is emitted before that byte changes any count.
    always_comb begin
        stlc_pkg::t_out_word tok, unk, fin;
        tok.token_kind         = e_kind;
        tok.unknown_char       = 8'd0;
        tok.lexeme_length      = e_len;
        tok.line_count         = 24'(r_lines);
        tok.empty_line_count   = 24'(r_empty);
        tok.comment_line_count = 24'(r_comm);
        tok.last_of_run        = 1'b0;
        unk                    = tok;
        unk.token_kind         = stlc_pkg::K_UNK;
        unk.unknown_char       = c;
        unk.lexeme_length      = 8'd1;
        unk.last_of_run        = 1'b1;
        fin                    = tok;
        fin.token_kind         = stlc_pkg::K_END;
        fin.lexeme_length      = 8'd0;
        fin.last_of_run        = 1'b1;
        res0 = tok;
        res1 = unk;
        if (i_in_word.end_of_stream) begin
            if (e_valid && (e_kind != stlc_pkg::K_ERR)) begin
                res1  = fin;
                res_n = 2'd2;
            end else if (e_valid) begin
                res0.last_of_run = 1'b1;
                res_n = 2'd1;
            end else begin
                res0  = fin;
                res_n = 2'd1;
            end
        end else if (e_valid && u_valid) begin
            res_n = 2'd2;
        end else if (e_valid) begin
            res0.last_of_run = 1'b1;
            res_n = 2'd1;
        end else if (u_valid) begin
            res0  = unk;
            res_n = 2'd1;
        end else begin
            res_n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_lsf    <= 1'b1;
            r_lines  <= '0;
            r_empty  <= '0;
            r_comm   <= '0;
            r_len    <= 8'd0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_mode   <= n_mode;
                r_lsf    <= n_lsf;
                r_lines  <= n_lines;
                r_empty  <= n_empty;
                r_comm   <= n_comm;
                r_len    <= n_len;
                r_wr_ptr <= r_wr_ptr + PW'(res_n);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (in_acc ? NW'(res_n) : NW'(0)) - (out_acc ? NW'(1) : NW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (res_n != 2'd0)) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_acc && (res_n == 2'd2)) begin
            r_queue[r_wr_ptr + 1'b1] <= res1;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(QD))
        else $error("Result queue holds more words than its depth.");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.end_of_stream) |=>
            (r_mode == M_IDLE) && r_lsf && (r_lines == '0) && (r_comm == '0))
        else $error("Lexer state not cleared after end of stream.");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_word.token_kind == stlc_pkg::K_END) ||
                         (o_out_word.token_kind == stlc_pkg::K_ERR)))
            |-> o_out_word.last_of_run)
        else $error("End or error word is not marked last of run.");

    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_word.token_kind == stlc_pkg::K_ID) ||
                         (o_out_word.token_kind == stlc_pkg::K_NUM)))
            |-> (o_out_word.lexeme_length != 8'd0))
        else $error("Identifier or number word with zero length.");

endmodule

`default_nettype wire

FILE: dv/tb_source_tokenizer_line_counter.sv
// Testbench for source_tokenizer_line_counter: a lexer model in the bench predicts each token word.
`timescale 1ns / 100ps

module tb_source_tokenizer_line_counter;

    typedef enum logic [2:0] {
        LX_IDLE, LX_IDENT, LX_NUMBER, LX_SLASH, LX_LINE, LX_BLOCK, LX_STAR, LX_CLOSED
    } t_lex_mode;

    localparam logic [23:0] COUNT_CAP  = 24'hFF_FFFF;
    localparam logic [7:0]  LEXEME_CAP = 8'hFF;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_CR      = 8'h0D;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                o_in_ready;
    stlc_pkg::t_in_word  in_word;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    stlc_pkg::t_out_word o_out_word;

    logic      src_gaps;
    logic      sink_stalls;
    int        stall_left = 0;
    int        items_sent = 0;
    int        words_seen = 0;
    int        mismatches = 0;

    t_lex_mode           lex_mode;
    logic                at_line_start;
    logic [23:0]         n_lines;
    logic [23:0]         n_empty;
    logic [23:0]         n_comment;
    logic [7:0]          lexeme_len;
    stlc_pkg::t_out_word held_word;
    logic                word_held = 1'b0;
    stlc_pkg::t_out_word expected_tokens[$];

    source_tokenizer_line_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [23:0] bump(input logic [23:0] v);
        return (v < COUNT_CAP) ? v + 24'd1 : COUNT_CAP;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == stlc_pkg::CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task lex_reset();
        lex_mode      = LX_IDLE;
        at_line_start = 1'b1;
        n_lines       = '0;
        n_empty       = '0;
        n_comment     = '0;
        lexeme_len    = '0;
    endtask

    task emit_token(input logic [2:0] kind, input logic [7:0] ch, input logic [7:0] len);
        if (word_held) begin
            expected_tokens.push_back(held_word);
        end
        held_word.token_kind         = kind;
        held_word.unknown_char       = ch;
        held_word.lexeme_length      = len;
        held_word.line_count         = n_lines;
        held_word.empty_line_count   = n_empty;
        held_word.comment_line_count = n_comment;
        held_word.last_of_run        = 1'b0;
        word_held = 1'b1;
    endtask

    task lex_from_idle(input logic [7:0] c);
        lex_mode = LX_IDLE;
        if (is_blank(c)) begin
            if (c == stlc_pkg::CH_NL) begin
                n_lines = bump(n_lines);
                if (at_line_start) begin
                    n_empty = bump(n_empty);
                end
                at_line_start = 1'b1;
            end
        end else if (c == stlc_pkg::CH_SLASH) begin
            lex_mode = LX_SLASH;
        end else begin
            at_line_start = 1'b0;
            if (is_letter(c)) begin
                lex_mode   = LX_IDENT;
                lexeme_len = 8'd1;
            end else if (is_digit(c)) begin
                lex_mode   = LX_NUMBER;
                lexeme_len = 8'd1;
            end else begin
                emit_token(stlc_pkg::K_UNK, c, 8'd1);
            end
        end
    endtask

    task comment_newline();
        n_lines = bump(n_lines);
        if (at_line_start) begin
            n_comment = bump(n_comment);
        end
    endtask

    task predict_tokens(input logic [7:0] c, input logic eos);
        if (eos) begin
            case (lex_mode)
                LX_IDENT: begin
                    emit_token(stlc_pkg::K_ID, 8'd0, lexeme_len);
                    emit_token(stlc_pkg::K_END, 8'd0, 8'd0);
                end
                LX_NUMBER: begin
                    emit_token(stlc_pkg::K_NUM, 8'd0, lexeme_len);
                    emit_token(stlc_pkg::K_END, 8'd0, 8'd0);
                end
                LX_SLASH: begin
                    at_line_start = 1'b0;
                    emit_token(stlc_pkg::K_DIV, 8'd0, 8'd1);
                    emit_token(stlc_pkg::K_END, 8'd0, 8'd0);
                end
                LX_BLOCK, LX_STAR: begin
                    emit_token(stlc_pkg::K_ERR, 8'd0, 8'd0);
                end
                default: begin
                    emit_token(stlc_pkg::K_END, 8'd0, 8'd0);
                end
            endcase
            lex_reset();
        end else begin
            case (lex_mode)
                LX_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == stlc_pkg::CH_UNDER) begin
                        if (lexeme_len < LEXEME_CAP) lexeme_len = lexeme_len + 8'd1;
                    end else begin
                        emit_token(stlc_pkg::K_ID, 8'd0, lexeme_len);
                        lex_from_idle(c);
                    end
                end
                LX_NUMBER: begin
                    if (is_digit(c)) begin
                        if (lexeme_len < LEXEME_CAP) lexeme_len = lexeme_len + 8'd1;
                    end else begin
                        emit_token(stlc_pkg::K_NUM, 8'd0, lexeme_len);
                        lex_from_idle(c);
                    end
                end
                LX_SLASH: begin
                    if (c == stlc_pkg::CH_STAR) begin
                        lex_mode = LX_BLOCK;
                    end else if (c == stlc_pkg::CH_SLASH) begin
                        if (at_line_start) n_comment = bump(n_comment);
                        at_line_start = 1'b0;
                        lex_mode      = LX_LINE;
                    end else begin
                        at_line_start = 1'b0;
                        emit_token(stlc_pkg::K_DIV, 8'd0, 8'd1);
                        lex_from_idle(c);
                    end
                end
                LX_LINE: begin
                    if (c == stlc_pkg::CH_NL) lex_from_idle(c);
                end
                LX_BLOCK: begin
                    if (c == stlc_pkg::CH_NL) begin
                        comment_newline();
                    end else if (c == stlc_pkg::CH_STAR) begin
                        lex_mode = LX_STAR;
                    end
                end
                LX_STAR: begin
                    if (c == stlc_pkg::CH_SLASH) begin
                        lex_mode = LX_CLOSED;
                    end else if (c != stlc_pkg::CH_STAR) begin
                        if (c == stlc_pkg::CH_NL) comment_newline();
                        lex_mode = LX_BLOCK;
                    end
                end
                LX_CLOSED: begin
                    if (c == stlc_pkg::CH_NL && at_line_start) n_comment = bump(n_comment);
                    at_line_start = 1'b0;
                    lex_from_idle(c);
                end
                default: begin
                    lex_from_idle(c);
                end
            endcase
        end
        if (word_held) begin
            held_word.last_of_run = 1'b1;
            expected_tokens.push_back(held_word);
            word_held = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                    words_seen, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        stlc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                flag_mismatch($sformatf("word %0d arrived with none expected: %h",
                                        words_seen, o_out_word));
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 24'(o_out_word.token_kind),
                            24'(want.token_kind));
                check_field("unknown_char", 24'(o_out_word.unknown_char),
                            24'(want.unknown_char));
                check_field("lexeme_length", 24'(o_out_word.lexeme_length),
                            24'(want.lexeme_length));
                check_field("line_count", o_out_word.line_count, want.line_count);
                check_field("empty_line_count", o_out_word.empty_line_count,
                            want.empty_line_count);
                check_field("comment_line_count", o_out_word.comment_line_count,
                            want.comment_line_count);
                check_field("last_of_run", 24'(o_out_word.last_of_run),
                            24'(want.last_of_run));
            end
            words_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0 && sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8);
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] ch, input logic eos);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{byte_req: ch, end_of_stream: eos};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        predict_tokens(ch, eos);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], 1'b0);
        end
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] ident_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(8'h61, 8'h7A));
            1: return 8'($urandom_range(8'h41, 8'h5A));
            2: return 8'($urandom_range(8'h30, 8'h39));
            default: return stlc_pkg::CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] comment_char();
        case ($urandom_range(0, 3))
            0: return stlc_pkg::CH_STAR;
            1: return stlc_pkg::CH_SLASH;
            2: return stlc_pkg::CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_tokens();
        send_text("aZ_9 07/x");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h08, 1'b0);
        send_text("_\t");
        send_word(8'h0B, 1'b0);
        send_word(8'h0C, 1'b0);
        send_text("\r");
        send_word(8'h0E, 1'b0);
        send_end();
    endtask

    task automatic test_comments();
        send_text("//x\n/***/b/*/ */\n");
        send_end();
    endtask

    task automatic test_line_counts();
        send_text("\n\n /**/\n/*\n*/x\n");
        send_end();
    endtask

    task automatic test_end_cases();
        send_text("ab");
        send_end();
        send_text("12");
        send_end();
        send_text("/");
        send_end();
        send_text("/*");
        send_end();
        send_text("/**");
        send_end();
        send_text("//q");
        send_end();
        send_text("/**/");
        send_end();
        send_end();
    endtask

    task automatic test_long_lexemes();
        send_word(8'h61, 1'b0);
        repeat (255) send_word(ident_char(), 1'b0);
        send_text(" ");
        repeat (256) send_word(8'($urandom_range(8'h30, 8'h39)), 1'b0);
        send_end();
    endtask

    task automatic test_random_source(input int n_items);
        int stop_at;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (sink_stalls || src_gaps) begin
                if ($urandom_range(0, 15) == 0) src_gaps = !src_gaps;
            end
            len = $urandom_range(0, 10);
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    send_word(is_letter(ident_char()) ? 8'h71 : 8'h4B, 1'b0);
                    repeat (len) send_word(ident_char(), 1'b0);
                end
                4, 5: begin
                    repeat (1 + len / 2) send_word(8'($urandom_range(8'h30, 8'h39)), 1'b0);
                end
                6: send_word(8'($urandom_range(0, 1) ? stlc_pkg::CH_SPACE
                                                      : $urandom_range(CH_TAB, CH_CR)), 1'b0);
                7: repeat (1 + len % 3) send_word(stlc_pkg::CH_NL, 1'b0);
                8: begin
                    send_text("//");
                    repeat (len) send_word(8'($urandom_range(0, 255)), 1'b0);
                    send_word(stlc_pkg::CH_NL, 1'b0);
                end
                9, 10: begin
                    send_text("/*");
                    repeat (len) send_word(comment_char(), 1'b0);
                    repeat ($urandom_range(1, 3)) send_word(stlc_pkg::CH_STAR, 1'b0);
                    send_word(stlc_pkg::CH_SLASH, 1'b0);
                end
                11: send_word(stlc_pkg::CH_SLASH, 1'b0);
                12, 15: send_word(8'($urandom_range(0, 255)), 1'b0);
                13: send_end();
                default: begin
                    if (len < 5) begin
                        send_text("/*");
                        repeat (len) send_word(comment_char(), 1'b0);
                        send_end();
                    end else begin
                        send_text("*/");
                    end
                end
            endcase
        end
        send_end();
    endtask

    initial begin
        lex_reset();
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tokens();
        test_comments();
        test_line_counts();
        test_end_cases();
        test_long_lexemes();
        test_random_source(40);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_source(20);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
